@@ src/assert_macros.svh @@
// Concurrent assertion macros used by the deque top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge out of reset
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define BDQ_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define BDQ_ASSERT(lbl, clk, rstn, prop, msg)

`define BDQ_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ src/bdq_pkg.sv @@
// Types, constants and helpers for the bounded double-ended queue
package bdq_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [PTR_W-1:0]         ptr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_NONE       = 3'd4
	} op_e;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_UNDERFLOW = 2'd1,
		ERR_OVERFLOW  = 2'd2
	} err_e;

	typedef struct packed {
		logic [2:0]               operation;
		logic signed [WORD_W-1:0] data_value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic [CNT_W-1:0]         entry_total;
		logic                     is_empty;
		logic                     is_full;
		logic [1:0]               error_code;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic exec;   // apply the accepted transaction to pointer, count and store
		logic fetch;  // read front and back slots
		logic emit;   // result cycle
	} ctl_cmd_t;

	// base + offset around the ring, offset at most DEPTH
	function automatic ptr_t ring_add(ptr_t base, cnt_t offset);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
		if (sum >= (CNT_W+1)'(DEPTH))
			sum = sum - (CNT_W+1)'(DEPTH);
		return PTR_W'(sum);
	endfunction

	function automatic ptr_t ring_dec(ptr_t base);
		return (base == '0) ? PTR_W'(DEPTH - 1) : base - PTR_W'(1);
	endfunction

endpackage

@@ src/bdq_ctrl.sv @@
// Sequencing state machine for the deque: accept, slot read, result
module bdq_ctrl
	import bdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_REPLY = 3'b100
	} state_e;

	state_e state_q;
	state_e state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_READ;
			end
			ST_READ:  state_d = ST_REPLY;
			ST_REPLY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign busy      = (state_q != ST_IDLE);
	assign cmd.exec  = (state_q == ST_IDLE) && start;
	assign cmd.fetch = (state_q == ST_READ);
	assign cmd.emit  = (state_q == ST_REPLY);
	assign done      = cmd.emit;

endmodule

@@ src/bdq_dpath.sv @@
// Ring storage, head pointer, count and result formatting for the deque
module bdq_dpath
	import bdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_cmd_t cmd,
	input  req_t     item,
	output rsp_t     result
);

	word_t slot_mem_q [DEPTH];

	ptr_t  head_q;
	cnt_t  count_q;
	err_e  err_q;
	word_t front_rd_q;
	word_t back_rd_q;

	ptr_t  head_d;
	cnt_t  count_d;
	err_e  err_d;
	logic  wr_en;
	ptr_t  wr_addr;
	ptr_t  back_addr;
	logic  empty;
	logic  full;

	assign empty = (count_q == '0);
	assign full  = (count_q >= CNT_W'(DEPTH));

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		err_d   = ERR_OK;
		wr_en   = 1'b0;
		wr_addr = head_q;
		unique case (item.operation)
			OP_PUSH_FRONT: begin
				if (full) begin
					err_d = ERR_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					wr_addr = ring_dec(head_q);
					head_d  = wr_addr;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					err_d = ERR_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					wr_addr = ring_add(head_q, count_q);
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					err_d = ERR_UNDERFLOW;
				end else begin
					head_d  = ring_add(head_q, CNT_W'(1));
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty)
					err_d = ERR_UNDERFLOW;
				else
					count_d = count_q - CNT_W'(1);
			end
			OP_NONE: err_d = ERR_OK;
			default: err_d = ERR_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			err_q   <= ERR_OK;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en)
			slot_mem_q[wr_addr] <= item.data_value;
	end

	// back slot is only meaningful when the count is non-zero
	assign back_addr = ring_add(head_q, count_q - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			front_rd_q <= slot_mem_q[head_q];
			back_rd_q  <= slot_mem_q[back_addr];
		end
	end

	assign result.front_value = empty ? '0 : front_rd_q;
	assign result.back_value  = empty ? '0 : back_rd_q;
	assign result.entry_total = count_q;
	assign result.is_empty    = empty;
	assign result.is_full     = full;
	assign result.error_code  = err_q;

endmodule

@@ src/bounded_double_ended_queue.sv @@
// Top level of the bounded double-ended queue: controller plus datapath
//
//  channel   signals               direction  transfer
//  item      start, busy, item     in         start high while busy low
//  result    done, result          out        one cycle with done high
//
// In each transaction the accept edge updates head, count and the store,
// the read state then loads the front and back slots into registers, and
// the result state presents the result with done.
// busy is high for the read and result cycles; a new item is taken from
// the cycle after done, so one item is finished before the next is taken.
// Reset clears head, count, the error code and the controller state; the result cannot be held off.
`include "assert_macros.svh"

module bounded_double_ended_queue
	import bdq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t item,
	output logic done,
	output rsp_t result
);

	ctl_cmd_t cmd;

	bdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	bdq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

	`BDQ_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "busy not raised after accept")
	`BDQ_ASSERT(a_done_busy, clk, arst_n, done |-> busy, "result strobe while idle")
	`BDQ_ASSERT(a_done_idle, clk, arst_n, done |=> !busy, "busy held after result")
	`BDQ_NEVER(a_empty_full, clk, arst_n, done && result.is_empty && result.is_full, "empty and full together")
	`BDQ_ASSERT(a_empty_zero, clk, arst_n, (done && result.is_empty) |-> (result.front_value == '0 && result.back_value == '0), "non-zero ends on empty queue")
	`BDQ_ASSERT(a_count_bound, clk, arst_n, done |-> (result.entry_total <= CNT_W'(DEPTH)), "count beyond depth")

endmodule

@@ tb/bounded_double_ended_queue_tb.sv @@
// Self-checking testbench for the bounded double-ended queue: directed and random transactions
module bounded_double_ended_queue_tb;
	import bdq_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 850;
	localparam int SETTLE       = 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t item;
	logic done;
	rsp_t result;

	int unsigned cycle_count;

	// Shadow deque: mirrors the ring and queues the status due for each transaction
	class status_scoreboard;
		word_t slot_copy [DEPTH];
		ptr_t  head;
		cnt_t  count;
		rsp_t  status_due [$];
		int    failures;

		function new();
			head     = '0;
			count    = '0;
			failures = 0;
		endfunction

		function int wrap(int idx);
			return idx % DEPTH;
		endfunction

		function void note_request(req_t r);
			rsp_t s;
			err_e code;
			code = ERR_OK;
			case (r.operation)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (count == CNT_W'(DEPTH)) begin
						code = ERR_OVERFLOW;
					end else if (r.operation == OP_PUSH_FRONT) begin
						head = ptr_t'(wrap(int'(head) + DEPTH - 1));
						slot_copy[head] = r.data_value;
						count++;
					end else begin
						slot_copy[wrap(int'(head) + int'(count))] = r.data_value;
						count++;
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (count == '0) begin
						code = ERR_UNDERFLOW;
					end else begin
						if (r.operation == OP_POP_FRONT)
							head = ptr_t'(wrap(int'(head) + 1));
						count--;
					end
				end
				default: ;  // none, and codes 5..7 alike
			endcase
			if (count == '0) begin
				s.front_value = '0;
				s.back_value  = '0;
			end else begin
				s.front_value = slot_copy[head];
				s.back_value  = slot_copy[wrap(int'(head) + int'(count) - 1)];
			end
			s.entry_total = count;
			s.is_empty    = (count == '0);
			s.is_full     = (count == CNT_W'(DEPTH));
			s.error_code  = code;
			status_due.push_back(s);
		endfunction

		function void check_status(rsp_t got);
			rsp_t want;
			if (status_due.size() == 0) begin
				$error("result with no transaction outstanding");
				failures++;
				return;
			end
			want = status_due.pop_front();
			if (got.front_value !== want.front_value) begin
				$error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
				failures++;
			end
			if (got.back_value !== want.back_value) begin
				$error("back_value: expected %0d, got %0d", want.back_value, got.back_value);
				failures++;
			end
			if (got.entry_total !== want.entry_total) begin
				$error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
				failures++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
				failures++;
			end
			if (got.is_full !== want.is_full) begin
				$error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
				failures++;
			end
			if (got.error_code !== want.error_code) begin
				$error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
				failures++;
			end
		endfunction
	endclass

	status_scoreboard sb;

	bounded_double_ended_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// check before note: a result always belongs to an earlier transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_status(result);
			if (start && !busy)
				sb.note_request(item);
		end
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("[bounded_double_ended_queue] ERROR");
		$finish;
	end

	function automatic word_t random_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic req_t make_request(logic [2:0] op, word_t v);
		req_t r;
		r.operation  = op;
		r.data_value = v;
		return r;
	endfunction

	// present one transaction and hold it until the edge that takes it
	task automatic send_request(req_t r);
		@(negedge clk);
		start <= 1'b1;
		item  <= r;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			item  <= make_request(3'($urandom), random_word());
		end
	endtask

	task automatic drain_status();
		@(negedge clk);
		start <= 1'b0;
		while (sb.status_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_request(make_request(OP_POP_FRONT, 32'sh12345678));
		send_request(make_request(OP_POP_BACK, -32'sd1));
		send_request(make_request(OP_NONE, 32'sh7fffffff));
		send_request(make_request(3'd5, 32'sh0badf00d));
		send_request(make_request(3'd6, 32'sh80000000));
		send_request(make_request(3'd7, -32'sd1));
		// fill from both ends, extremes first
		send_request(make_request(OP_PUSH_FRONT, 32'sh7fffffff));
		send_request(make_request(OP_PUSH_BACK, 32'sh80000000));
		send_request(make_request(OP_PUSH_FRONT, '0));
		send_request(make_request(OP_PUSH_BACK, -32'sd1));
		send_request(make_request(OP_PUSH_FRONT, 32'sh55555555));
		send_request(make_request(OP_PUSH_BACK, 32'shaaaaaaaa));
		for (int i = 0; i < 10; i++)
			send_request(make_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, word_t'($urandom)));
		send_request(make_request(OP_PUSH_FRONT, 32'sh11111111));
		send_request(make_request(OP_PUSH_BACK, 32'sh22222222));
		send_request(make_request(OP_POP_FRONT, '0));
		send_request(make_request(OP_POP_BACK, '0));
	endtask

	initial begin
		int         mode;
		int         roll;
		logic [2:0] op;

		sb          = new();
		cycle_count = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		drain_status();

		mode = 2;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// push-heavy, pop-heavy or balanced stretches walk the count end to end
			if (n % 40 == 0)
				mode = $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = OP_NONE;
			else if (roll < 5)
				op = 3'($urandom_range(5, 7));
			else if (roll < ((mode == 0) ? 77 : (mode == 1) ? 29 : 53))
				op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
			send_request(make_request(op, random_word()));
			// the read and result states fall inside the hold-off, so only the rest of it is idle time
			if ((n < 300 || n >= 500) && $urandom_range(0, 99) < 8)
				hold_off($urandom_range(3, 6));
			if (n == RANDOM_ITEMS / 2)
				drain_status();
		end

		drain_status();
		repeat (SETTLE) @(posedge clk);
		if (sb.status_due.size() != 0) begin
			$error("%0d results never arrived", sb.status_due.size());
			sb.failures++;
		end
		if (sb.failures == 0)
			$display("[bounded_double_ended_queue] OK");
		else
			$display("[bounded_double_ended_queue] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/bdq_pkg.sv
src/bdq_ctrl.sv
src/bdq_dpath.sv
src/bounded_double_ended_queue.sv
tb/bounded_double_ended_queue_tb.sv
